// ===== design/pit_pkg.sv =====
`timescale 1ns / 1ps

package pit_pkg;

    // default table geometry
    localparam int NUM_SLICES_DEF   = 256;
    localparam int NUM_FACES_DEF    = 16;
    // faces reachable through the 4-bit face field
    localparam int FACE_FIELD_LIMIT = 16;

    // reset value of the forward delay register, in tenths
    localparam logic [7:0] FWD_DELAY_RESET = 8'd1;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CONTENT = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } pit_op_t;

    typedef enum logic [2:0] {
        STAT_ACCEPTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FORWARDED = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_CLEARED   = 3'd4
    } pit_status_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  slice;
        logic [3:0]  face;
        logic [15:0] content_id;
        logic [31:0] arrival_time;
    } pit_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  to_face;
        logic [3:0]  from_face;
        logic [15:0] out_content;
        logic [7:0]  out_slice;
        logic [31:0] send_time;
        logic        table_empty;
        logic        last;
    } pit_out_t;

endpackage

// ===== design/pending_interest_table.sv =====
`timescale 1ns / 1ps

// Pending interest table: one face bitmask per slice in a single-port-write,
// registered-read memory. After reset the table is swept clear, one entry per
// cycle, with s_ready low. Add and clear words go through accept, then table
// read and write-back; a content word goes through accept and table read,
// then its forwarded words, one per pending face, leave one per cycle
// through the output register while m_ready allows. The output register
// lets a finished word wait on m_ready. forward_delay is to be written through
// cfg_wr_en and cfg_wr_data only while the block is idle; nothing enforces it.
module pending_interest_table
    import pit_pkg::*;
#(
    parameter int NUM_SLICES = NUM_SLICES_DEF,
    parameter int NUM_FACES  = NUM_FACES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic     s_valid,
    output logic     s_ready,
    input  pit_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pit_out_t m_data
);

    localparam int MASK_W = (NUM_FACES < FACE_FIELD_LIMIT) ? NUM_FACES : FACE_FIELD_LIMIT;
    localparam int ADDR_W = $clog2(NUM_SLICES);

    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [MASK_W-1:0] mem_rd_data;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [MASK_W-1:0] mem_wr_data;

    // face mask store
    pit_mem #(
        .DEPTH  (NUM_SLICES),
        .WIDTH  (MASK_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // sequencer and output register
    pit_ctrl #(
        .NUM_SLICES (NUM_SLICES),
        .NUM_FACES  (NUM_FACES),
        .MASK_W     (MASK_W),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // table sweep follows reset, no word taken
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("word taken right after reset");

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken during table access");

    // only forwarded fan-out spans several result words
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != STAT_FORWARDED)) |-> m_data.last)
        else $error("non-forward result without last");

    // a fresh interest leaves the table occupied
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STAT_ACCEPTED)) |-> !m_data.table_empty)
        else $error("accepted interest reports empty table");

endmodule

// ===== design/pit_mem.sv =====
`timescale 1ns / 1ps

module pit_mem
    import pit_pkg::*;
#(
    parameter int DEPTH  = NUM_SLICES_DEF,
    parameter int WIDTH  = FACE_FIELD_LIMIT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/pit_ctrl.sv =====
`timescale 1ns / 1ps

module pit_ctrl
    import pit_pkg::*;
#(
    parameter int NUM_SLICES = NUM_SLICES_DEF,
    parameter int NUM_FACES  = NUM_FACES_DEF,
    parameter int MASK_W     = (NUM_FACES < FACE_FIELD_LIMIT) ? NUM_FACES : FACE_FIELD_LIMIT,
    parameter int ADDR_W     = $clog2(NUM_SLICES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  pit_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pit_out_t          m_data,
    output logic              mem_rd_en,
    output logic [ADDR_W-1:0] mem_rd_addr,
    input  logic [MASK_W-1:0] mem_rd_data,
    output logic              mem_wr_en,
    output logic [ADDR_W-1:0] mem_wr_addr,
    output logic [MASK_W-1:0] mem_wr_data
);

    localparam int CNT_W = $clog2(NUM_SLICES + 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EMIT  = 4'b1000
    } pit_state_t;

    pit_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        delay_reg;
    pit_in_t           item_reg;
    logic [MASK_W-1:0] pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    pit_out_t          out_reg, out_next;

    logic              s_accept;
    logic              out_free;
    logic              load_out;
    logic [31:0]       slice_in_w;
    logic [31:0]       slice_item_w;
    logic              slice_ok;
    logic              face_ok;
    logic [MASK_W-1:0] face_bit;
    logic [MASK_W-1:0] cur_mask;
    logic [MASK_W-1:0] rest_mask;
    logic [3:0]        first_face;

    assign s_accept     = s_valid && s_ready;
    assign s_ready      = (state_reg == S_IDLE);
    assign out_free     = !m_valid_reg || m_ready;
    assign slice_in_w   = 32'(s_data.slice);
    assign slice_item_w = 32'(item_reg.slice);
    assign slice_ok     = slice_item_w < 32'(NUM_SLICES);
    assign face_ok      = 32'(item_reg.face) < 32'(NUM_FACES);
    assign face_bit     = MASK_W'(1) << item_reg.face;
    assign cur_mask     = slice_ok ? mem_rd_data : '0;

    // table read is issued at accept
    assign mem_rd_en   = s_accept;
    assign mem_rd_addr = slice_in_w[ADDR_W-1:0];

    // lowest pending face for fan-out
    always_comb begin
        first_face = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                first_face = 4'(i);
            end
        end
    end
    assign rest_mask = pend_reg & (pend_reg - MASK_W'(1));

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        load_out      = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = slice_item_w[ADDR_W-1:0];
        mem_wr_data   = '0;

        out_next             = '0;
        out_next.to_face     = item_reg.face;
        out_next.out_slice   = item_reg.slice;
        out_next.last        = 1'b1;

        unique case (state_reg)
            S_CLEAR: begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(NUM_SLICES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (item_reg.op == OP_NONE) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    unique case (item_reg.op)
                        OP_ADD: begin
                            load_out   = 1'b1;
                            state_next = S_IDLE;
                            if (!slice_ok || !face_ok) begin
                                out_next.status = STAT_NOT_FOUND;
                            end else if ((cur_mask & face_bit) != '0) begin
                                out_next.status = STAT_DUPLICATE;
                            end else begin
                                out_next.status = STAT_ACCEPTED;
                                mem_wr_en       = 1'b1;
                                mem_wr_data     = cur_mask | face_bit;
                                if (cur_mask == '0) begin
                                    cnt_next = cnt_reg + CNT_W'(1);
                                end
                            end
                            out_next.table_empty = (cnt_next == '0);
                        end
                        OP_CONTENT: begin
                            if (cur_mask == '0) begin
                                load_out             = 1'b1;
                                out_next.status      = STAT_NOT_FOUND;
                                out_next.table_empty = 1'b1;
                                state_next           = S_IDLE;
                            end else begin
                                mem_wr_en  = 1'b1;
                                cnt_next   = cnt_reg - CNT_W'(1);
                                pend_next  = cur_mask;
                                state_next = S_EMIT;
                            end
                        end
                        OP_CLEAR: begin
                            load_out        = 1'b1;
                            out_next.status = STAT_CLEARED;
                            state_next      = S_IDLE;
                            if (cur_mask != '0) begin
                                mem_wr_en = 1'b1;
                                cnt_next  = cnt_reg - CNT_W'(1);
                            end
                            out_next.table_empty = (cnt_next == '0);
                        end
                        OP_NONE: begin
                            state_next = S_IDLE;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                out_next.status      = STAT_FORWARDED;
                out_next.to_face     = first_face;
                out_next.from_face   = item_reg.face;
                out_next.out_content = item_reg.content_id;
                out_next.send_time   = item_reg.arrival_time + 32'(delay_reg);
                out_next.table_empty = (cnt_reg == '0);
                out_next.last        = (rest_mask == '0);
                if (out_free) begin
                    load_out  = 1'b1;
                    pend_next = rest_mask;
                    if (rest_mask == '0) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
            delay_reg    <= FWD_DELAY_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                delay_reg <= cfg_wr_data;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_data;
        end
        if (load_out) begin
            out_reg <= out_next;
        end
        pend_reg <= pend_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sim/tb_pending_interest_table.sv =====
`timescale 1ns / 1ps

module tb_pending_interest_table;
    import pit_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_WORDS   = 125;

    // one directed row: input word, and a hand-typed result where it is obvious
    typedef struct {
        pit_in_t  w;
        bit       typed;
        pit_out_t want;
    } dir_row_t;

    // per accepted word: whether the typed result replaces the predicted one
    typedef struct {
        bit       typed;
        pit_out_t want;
    } word_note_t;

    logic     aclk        = 1'b0;
    logic     aresetn     = 1'b0;
    logic     cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic     s_valid     = 1'b0;
    logic     s_ready;
    pit_in_t  s_data      = '0;
    logic     m_valid;
    logic     m_ready     = 1'b0;
    pit_out_t m_data;

    // table copy kept by the testbench
    logic [15:0] face_mask_m [NUM_SLICES_DEF];
    int          pending_slices;
    logic [7:0]  fwd_delay_m;

    pit_out_t   want_words [$];
    word_note_t word_notes [$];
    dir_row_t   dir_rows [$];
    logic [7:0] hot_slices [8];

    int send_idle  = 0;
    int recv_stall = 0;
    int errors     = 0;
    int quiet      = 0;
    int words_sent = 0;

    pending_interest_table u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // apply one word to the table copy, queue the words it should produce
    task automatic step_table(input pit_in_t w);
        logic [15:0] mask;
        logic [31:0] send;
        pit_out_t    r;
        int          total;
        int          n;
        int          f;
        r = '0;
        r.to_face   = w.face;
        r.out_slice = w.slice;
        r.last      = 1'b1;
        mask = face_mask_m[w.slice];
        case (w.op)
            OP_ADD: begin
                if (mask[w.face]) begin
                    r.status = STAT_DUPLICATE;
                end else begin
                    if (mask == 16'd0)
                        pending_slices++;
                    face_mask_m[w.slice][w.face] = 1'b1;
                    r.status = STAT_ACCEPTED;
                end
                r.table_empty = (pending_slices == 0);
                want_words.push_back(r);
            end
            OP_CONTENT: begin
                if (mask == 16'd0) begin
                    r.status      = STAT_NOT_FOUND;
                    r.table_empty = 1'b1;
                    want_words.push_back(r);
                end else begin
                    face_mask_m[w.slice] = 16'd0;
                    pending_slices--;
                    send  = w.arrival_time + {24'd0, fwd_delay_m};
                    total = $countones(mask);
                    n     = 0;
                    // one forward per pending face, lowest face first
                    for (f = 0; f < NUM_FACES_DEF; f++) begin
                        if (mask[f]) begin
                            r.status      = STAT_FORWARDED;
                            r.to_face     = f[3:0];
                            r.from_face   = w.face;
                            r.out_content = w.content_id;
                            r.send_time   = send;
                            r.table_empty = (pending_slices == 0);
                            r.last        = ((n + 1) == total);
                            want_words.push_back(r);
                            n++;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                if (mask != 16'd0) begin
                    face_mask_m[w.slice] = 16'd0;
                    pending_slices--;
                end
                r.status      = STAT_CLEARED;
                r.table_empty = (pending_slices == 0);
                want_words.push_back(r);
            end
            default: ;
        endcase
    endtask

    // handshake monitor, checker and watchdog
    always @(posedge aclk) begin : monitor
        word_note_t nt;
        pit_out_t   exp_w;
        if (aresetn) begin
            quiet++;
            if (s_valid && s_ready) begin
                quiet = 0;
                nt = word_notes.pop_front();
                step_table(s_data);
                if (nt.typed)
                    want_words[want_words.size() - 1] = nt.want;
            end
            if (m_valid && m_ready) begin
                quiet = 0;
                if (want_words.size() == 0) begin
                    report($sformatf("unexpected word %h", m_data));
                end else begin
                    exp_w = want_words.pop_front();
                    check_field("status", 32'(m_data.status), 32'(exp_w.status));
                    check_field("to_face", 32'(m_data.to_face), 32'(exp_w.to_face));
                    check_field("from_face", 32'(m_data.from_face),
                                32'(exp_w.from_face));
                    check_field("out_content", 32'(m_data.out_content),
                                32'(exp_w.out_content));
                    check_field("out_slice", 32'(m_data.out_slice),
                                32'(exp_w.out_slice));
                    check_field("send_time", m_data.send_time, exp_w.send_time);
                    check_field("table_empty", 32'(m_data.table_empty),
                                32'(exp_w.table_empty));
                    check_field("last", 32'(m_data.last), 32'(exp_w.last));
                end
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // present one word and hold it until accepted
    task automatic send_word(input pit_in_t w, input bit typed, input pit_out_t want);
        word_note_t nt;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        nt.typed = typed;
        nt.want  = want;
        word_notes.push_back(nt);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (w.op != OP_NONE)
            words_sent++;
    endtask

    // stop sending and let every outstanding result drain
    task automatic settle();
        s_valid <= 1'b0;
        while (want_words.size() != 0 || word_notes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_delay(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        fwd_delay_m = v;
    endtask

    function automatic pit_in_t make_word(input logic [1:0] op, input logic [7:0] slice,
                                          input logic [3:0] face);
        pit_in_t w;
        w.op         = op;
        w.slice      = slice;
        w.face       = face;
        w.content_id = 16'($urandom_range(0, 65535));
        // arrival times near both ends so the delay sum wraps now and then
        case ($urandom_range(0, 9))
            0:       w.arrival_time = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
            1:       w.arrival_time = 32'($urandom_range(0, 300));
            default: w.arrival_time = $urandom;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] pick_slice();
        if ($urandom_range(0, 99) < 70)
            return hot_slices[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic dir_row_t make_row(input pit_op_t op, input logic [7:0] slice,
                                          input logic [3:0] face, input logic [15:0] cid,
                                          input logic [31:0] tm, input bit typed,
                                          input pit_status_t st, input logic empty);
        dir_row_t r;
        r.w     = '{op: op, slice: slice, face: face, content_id: cid, arrival_time: tm};
        r.typed = typed;
        r.want  = '{status: st, to_face: face, from_face: 4'd0, out_content: 16'd0,
                    out_slice: slice, send_time: 32'd0, table_empty: empty, last: 1'b1};
        return r;
    endfunction

    // random traffic: mostly fill-then-fetch bursts on a few hot slices
    task automatic run_random(input int n_words);
        int         target;
        int         nf;
        int         i;
        logic [7:0] sl;
        logic [3:0] rot;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(0, 99) < 3)
                settle();
            case ($urandom_range(0, 9)) inside
                [0:5]: begin
                    sl  = pick_slice();
                    nf  = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 6);
                    rot = 4'($urandom_range(0, 15));
                    for (i = 0; i < nf; i++)
                        send_word(make_word(OP_ADD, sl,
                                  (nf == 16) ? 4'(i) + rot : 4'($urandom_range(0, 15))),
                                  1'b0, '0);
                    send_word(make_word(($urandom_range(0, 99) < 85) ? OP_CONTENT
                                                                      : OP_CLEAR,
                                        sl, 4'($urandom_range(0, 15))), 1'b0, '0);
                end
                [6:7]: begin
                    send_word(make_word(2'($urandom_range(0, 3)), pick_slice(),
                                        4'($urandom_range(0, 15))), 1'b0, '0);
                end
                default: begin
                    send_word(make_word(($urandom_range(0, 1) == 0) ? OP_CONTENT
                                                                   : OP_CLEAR,
                                        pick_slice(), 4'($urandom_range(0, 15))),
                              1'b0, '0);
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int p;
        int k;
        for (k = 0; k < NUM_SLICES_DEF; k++)
            face_mask_m[k] = 16'd0;
        pending_slices = 0;
        fwd_delay_m    = FWD_DELAY_RESET;

        // directed rows
        dir_rows.push_back(make_row(OP_CONTENT, 8'd0, 4'd3, 16'h1234, 32'd7,
                                    1'b1, STAT_NOT_FOUND, 1'b1));
        dir_rows.push_back(make_row(OP_CLEAR, 8'd255, 4'd5, 16'd0, 32'd0,
                                    1'b1, STAT_CLEARED, 1'b1));
        dir_rows.push_back(make_row(OP_ADD, 8'd0, 4'd0, 16'd0, 32'd0,
                                    1'b1, STAT_ACCEPTED, 1'b0));
        dir_rows.push_back(make_row(OP_ADD, 8'd0, 4'd0, 16'hFFFF, 32'hFFFF_FFFF,
                                    1'b1, STAT_DUPLICATE, 1'b0));
        dir_rows.push_back(make_row(OP_ADD, 8'd255, 4'd15, 16'd0, 32'd0,
                                    1'b1, STAT_ACCEPTED, 1'b0));
        dir_rows.push_back(make_row(OP_ADD, 8'd0, 4'd15, 16'd0, 32'd0,
                                    1'b1, STAT_ACCEPTED, 1'b0));
        dir_rows.push_back(make_row(OP_NONE, 8'd0, 4'd0, 16'd0, 32'd0,
                                    1'b0, STAT_ACCEPTED, 1'b0));
        // two forwards, send time wraps past the top
        dir_rows.push_back(make_row(OP_CONTENT, 8'd0, 4'd15, 16'hFFFF, 32'hFFFF_FFFF,
                                    1'b0, STAT_FORWARDED, 1'b0));
        dir_rows.push_back(make_row(OP_CONTENT, 8'd0, 4'd0, 16'h00FF, 32'd100,
                                    1'b1, STAT_NOT_FOUND, 1'b1));
        dir_rows.push_back(make_row(OP_CLEAR, 8'd255, 4'd15, 16'd0, 32'd0,
                                    1'b1, STAT_CLEARED, 1'b1));
        dir_rows.push_back(make_row(OP_CLEAR, 8'd255, 4'd0, 16'd0, 32'd0,
                                    1'b1, STAT_CLEARED, 1'b1));
        dir_rows.push_back(make_row(OP_ADD, 8'd85, 4'd5, 16'hAAAA, 32'h5555_5555,
                                    1'b1, STAT_ACCEPTED, 1'b0));
        dir_rows.push_back(make_row(OP_ADD, 8'd85, 4'd10, 16'h5555, 32'hAAAA_AAAA,
                                    1'b1, STAT_ACCEPTED, 1'b0));
        dir_rows.push_back(make_row(OP_ADD, 8'd170, 4'd0, 16'd0, 32'd0,
                                    1'b1, STAT_ACCEPTED, 1'b0));
        dir_rows.push_back(make_row(OP_CONTENT, 8'd85, 4'd0, 16'd0, 32'd0,
                                    1'b0, STAT_FORWARDED, 1'b0));
        dir_rows.push_back(make_row(OP_NONE, 8'd170, 4'd15, 16'hFFFF, 32'hFFFF_FFFF,
                                    1'b0, STAT_ACCEPTED, 1'b0));
        dir_rows.push_back(make_row(OP_CLEAR, 8'd170, 4'd15, 16'd0, 32'd0,
                                    1'b1, STAT_CLEARED, 1'b1));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k])
            send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);

        // random phases, each under its own delay and idling mix
        for (p = 0; p < 4; p++) begin
            settle();
            case (p)
                0:       set_delay(8'd0);
                1:       set_delay(8'd255);
                default: set_delay(8'($urandom_range(2, 254)));
            endcase
            hot_slices[0] = 8'd0;
            hot_slices[1] = 8'd255;
            for (k = 2; k < 8; k++)
                hot_slices[k] = 8'($urandom_range(0, 255));
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 75; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 75; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            run_random(PHASE_WORDS);
        end

        settle();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
